### sv/atbp_pkg.sv
// ----------------------------------------------------------------------------
// atbp_pkg: shared types and constants of the affine tile background
// Word formats, configuration layout and command / register codes.
// ----------------------------------------------------------------------------
package atbp_pkg;

	localparam int LINE_WIDTH = 256;
	localparam int BANK_AW    = 14;

	// command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_RENDER = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_MATRIX_A    = 3'd0;
	localparam logic [2:0] CFG_MATRIX_B    = 3'd1;
	localparam logic [2:0] CFG_MATRIX_C    = 3'd2;
	localparam logic [2:0] CFG_MATRIX_D    = 3'd3;
	localparam logic [2:0] CFG_SCROLL      = 3'd4;
	localparam logic [2:0] CFG_CENTER      = 3'd5;
	localparam logic [2:0] CFG_MODE        = 3'd6;
	localparam logic [2:0] CFG_LAYER_CODES = 3'd7;

	// repeat modes that treat the outside of the field specially
	localparam logic [1:0] REPEAT_TILE0 = 2'd2;
	localparam logic [1:0] REPEAT_CLIP  = 2'd3;

	localparam logic signed [9:0] ROW_FLIP_BASE = 10'sd223;

	typedef struct packed {
		logic        command;
		logic [14:0] address;
		logic [7:0]  data;
		logic [7:0]  line;
		logic [7:0]  column;
	} in_word_t;

	typedef struct packed {
		logic [7:0] screen_x;
		logic [7:0] color;
		logic [7:0] layer_code;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] matrix_a;
		logic signed [15:0] matrix_b;
		logic signed [15:0] matrix_c;
		logic signed [15:0] matrix_d;
		logic [31:0]        scroll_offsets;
		logic [31:0]        center_point;
		logic [4:0]         mode_flags;
		logic [23:0]        layer_codes;
	} cfg_t;

	// transformed word leaving the affine stages
	typedef struct packed {
		logic               vld;
		logic               command;
		logic [14:0]        address;
		logic [7:0]         data;
		logic [7:0]         column;
		logic signed [21:0] px;
		logic signed [21:0] py;
	} map_word_t;

endpackage

### sv/affine_tile_background_pixel.sv
// ----------------------------------------------------------------------------
// affine_tile_background_pixel: affine tiled background pixel unit
// Video memory, matrix mapping, tile and texel fetch, pixel output.
// ----------------------------------------------------------------------------
// Use:
//   Command words enter on cmd_word and are taken at a clock edge with start
//   high and busy low. A write word stores one byte into video memory; a
//   render word maps (line, column) through the matrix and fetches a texel.
//   Results leave on pix_word, valid for the single cycle strobe is high;
//   the receiver cannot hold them off. Write words and transparent pixels
//   give no result, nor do pixels clipped in REPEAT_CLIP mode.
//   Throughput: one word per cycle while busy is low, any mix of writes and renders.
//   Path: an accepted word passes three affine stages, the tile-map read,
//   the texel read and the output register.
//   Memory: split into an even bank (tile map) and an odd bank (texels),
//   each 16 KiB with one port. A write is applied to its bank at the stage
//   where that bank is read, so reads and writes keep word order.
//   Reset: registers clear, then a clearing pass zeroes both banks in
//   parallel, one byte each per cycle, with busy high.
//   Configuration writes are taken at any time, including the clearing pass,
//   and should be made while no render word is in flight.
// ----------------------------------------------------------------------------
module affine_tile_background_pixel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  atbp_pkg::in_word_t   cmd_word,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 strobe,
	output atbp_pkg::out_word_t  pix_word
);
	import atbp_pkg::*;

	localparam logic [7:0] X_LAST = 8'(LINE_WIDTH - 1);

	cfg_t               cfg_q;
	logic               clearing_q;
	logic [BANK_AW-1:0] clr_addr_q;
	logic               accept;
	map_word_t          map_word;

	// tile-map stage
	logic               outside;
	logic [BANK_AW-1:0] map_idx;
	logic               even_we, odd_we;
	logic [BANK_AW-1:0] even_addr, odd_addr;
	logic [7:0]         even_wdata, odd_wdata;
	logic [7:0]         tile_s4, texel_s5;

	logic               vld_s4, cmd_s4, blank_s4;
	logic [14:0]        addr_s4;
	logic [7:0]         data_s4, col_s4;
	logic [5:0]         fine_s4;

	logic               draw_s5;
	logic [7:0]         col_s5;

	logic [7:0]         color, layer;
	logic               strobe_q;
	out_word_t          pix_q;

	assign busy   = clearing_q;
	assign accept = start & ~clearing_q;

	// ---------------- configuration registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MATRIX_A:    cfg_q.matrix_a       <= cfg_data[15:0];
				CFG_MATRIX_B:    cfg_q.matrix_b       <= cfg_data[15:0];
				CFG_MATRIX_C:    cfg_q.matrix_c       <= cfg_data[15:0];
				CFG_MATRIX_D:    cfg_q.matrix_d       <= cfg_data[15:0];
				CFG_SCROLL:      cfg_q.scroll_offsets <= cfg_data;
				CFG_CENTER:      cfg_q.center_point   <= cfg_data;
				CFG_MODE:        cfg_q.mode_flags     <= cfg_data[4:0];
				CFG_LAYER_CODES: cfg_q.layer_codes    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// ---------------- clearing pass after reset ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- stages 1 to 3: coordinate mapping ----------------
	atbp_affine u_affine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (accept),
		.in_word  (cmd_word),
		.cfg      (cfg_q),
		.map_word (map_word)
	);

	// ---------------- stage 4: tile-map read (even bank) ----------------
	// inside the 1024x1024 field exactly when the bits above bit 9 are clear
	assign outside = (|map_word.px[21:10]) | (|map_word.py[21:10]);
	assign map_idx = (cfg_q.mode_flags[1:0] == REPEAT_TILE0 && outside) ? '0
	               : {map_word.py[9:3], map_word.px[9:3]};

	assign even_we    = clearing_q | (map_word.vld & (map_word.command == CMD_WRITE)
	                                  & ~map_word.address[0]);
	assign even_addr  = clearing_q ? clr_addr_q
	                  : (map_word.command == CMD_WRITE) ? map_word.address[14:1] : map_idx;
	assign even_wdata = clearing_q ? 8'h00 : map_word.data;

	atbp_bank u_map_bank (
		.clk   (clk),
		.we    (even_we),
		.addr  (even_addr),
		.wdata (even_wdata),
		.rdata (tile_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= map_word.vld;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s4   <= map_word.command;
		addr_s4  <= map_word.address;
		data_s4  <= map_word.data;
		col_s4   <= map_word.column;
		fine_s4  <= {map_word.py[2:0], map_word.px[2:0]};
		blank_s4 <= (cfg_q.mode_flags[1:0] == REPEAT_CLIP) & outside;
	end

	// ---------------- stage 5: texel read (odd bank) ----------------
	assign odd_we    = clearing_q | (vld_s4 & (cmd_s4 == CMD_WRITE) & addr_s4[0]);
	assign odd_addr  = clearing_q ? clr_addr_q
	                 : (cmd_s4 == CMD_WRITE) ? addr_s4[14:1] : {tile_s4, fine_s4};
	assign odd_wdata = clearing_q ? 8'h00 : data_s4;

	atbp_bank u_texel_bank (
		.clk   (clk),
		.we    (odd_we),
		.addr  (odd_addr),
		.wdata (odd_wdata),
		.rdata (texel_s5)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_s5 <= 1'b0;
		end else begin
			draw_s5 <= vld_s4 & (cmd_s4 == CMD_RENDER) & ~blank_s4;
		end
	end

	always_ff @(posedge clk) begin
		col_s5 <= col_s4;
	end

	// ---------------- stage 6: colour, layer, output register ----------------
	// extended layer: bit 7 picks the priority, 7 colour bits remain
	always_comb begin
		if (cfg_q.mode_flags[2]) begin
			color = {1'b0, texel_s5[6:0]};
			layer = texel_s5[7] ? cfg_q.layer_codes[23:16] : cfg_q.layer_codes[15:8];
		end else begin
			color = texel_s5;
			layer = cfg_q.layer_codes[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= draw_s5 & (color != 8'h00);
		end
	end

	always_ff @(posedge clk) begin
		pix_q.screen_x   <= cfg_q.mode_flags[4] ? X_LAST - col_s5 : col_s5;
		pix_q.color      <= color;
		pix_q.layer_code <= layer;
	end

	assign strobe   = strobe_q;
	assign pix_word = pix_q;

endmodule

### sv/atbp_affine.sv
// ----------------------------------------------------------------------------
// atbp_affine: affine coordinate stages
// Three registered stages: offset terms, matrix products, sums and scaling.
// ----------------------------------------------------------------------------
module atbp_affine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  atbp_pkg::in_word_t   in_word,
	input  atbp_pkg::cfg_t       cfg,
	output atbp_pkg::map_word_t  map_word
);
	import atbp_pkg::*;

	logic signed [15:0] hofs, vofs, cx, cy;
	logic signed [16:0] hdiff, vdiff;
	logic signed [10:0] hclip, vclip;
	logic signed [9:0]  row_base;
	logic signed [11:0] row, colterm;
	logic signed [29:0] sum_x, sum_y;

	logic               vld_s1, vld_s2, vld_s3;
	logic               cmd_s1, cmd_s2, cmd_s3;
	logic [14:0]        addr_s1, addr_s2, addr_s3;
	logic [7:0]         data_s1, data_s2, data_s3;
	logic [7:0]         col_s1, col_s2, col_s3;
	logic signed [11:0] row_s1, colterm_s1;
	logic signed [27:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [21:0] px_s3, py_s3;

	assign hofs = cfg.scroll_offsets[15:0];
	assign vofs = cfg.scroll_offsets[31:16];
	assign cx   = cfg.center_point[15:0];
	assign cy   = cfg.center_point[31:16];

	// 10-bit clip, sign from bit 13
	assign hdiff = {hofs[15], hofs} - {cx[15], cx};
	assign vdiff = {vofs[15], vofs} - {cy[15], cy};
	assign hclip = {hdiff[13], hdiff[9:0]};
	assign vclip = {vdiff[13], vdiff[9:0]};

	assign row_base = cfg.mode_flags[3] ? ROW_FLIP_BASE - signed'({2'b00, in_word.line})
	                                    : signed'({2'b00, in_word.line});
	assign row      = {{2{row_base[9]}}, row_base} + {vclip[10], vclip};
	assign colterm  = {hclip[10], hclip} + signed'({4'b0000, in_word.column});

	// floor(x / 256) is the top bits of the sum
	assign sum_x = {{2{pa_s2[27]}}, pa_s2} + {{2{pb_s2[27]}}, pb_s2}
	             + {{6{cx[15]}}, cx, 8'h00};
	assign sum_y = {{2{pc_s2[27]}}, pc_s2} + {{2{pd_s2[27]}}, pd_s2}
	             + {{6{cy[15]}}, cy, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1     <= in_word.command;
		addr_s1    <= in_word.address;
		data_s1    <= in_word.data;
		col_s1     <= in_word.column;
		row_s1     <= row;
		colterm_s1 <= colterm;

		cmd_s2  <= cmd_s1;
		addr_s2 <= addr_s1;
		data_s2 <= data_s1;
		col_s2  <= col_s1;
		pa_s2   <= cfg.matrix_a * colterm_s1;
		pb_s2   <= cfg.matrix_b * row_s1;
		pc_s2   <= cfg.matrix_c * colterm_s1;
		pd_s2   <= cfg.matrix_d * row_s1;

		cmd_s3  <= cmd_s2;
		addr_s3 <= addr_s2;
		data_s3 <= data_s2;
		col_s3  <= col_s2;
		px_s3   <= sum_x[29:8];
		py_s3   <= sum_y[29:8];
	end

	assign map_word = '{vld: vld_s3, command: cmd_s3, address: addr_s3, data: data_s3,
	                    column: col_s3, px: px_s3, py: py_s3};

endmodule

### sv/atbp_bank.sv
// ----------------------------------------------------------------------------
// atbp_bank: one byte-wide video memory bank
// Single port, write or read each cycle, registered read data.
// ----------------------------------------------------------------------------
module atbp_bank (
	input  logic                          clk,
	input  logic                          we,
	input  logic [atbp_pkg::BANK_AW-1:0]  addr,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    rdata
);
	import atbp_pkg::*;

	logic [7:0] mem [2**BANK_AW];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### sv/atbp_checker.sv
// ----------------------------------------------------------------------------
// atbp_checker: port-level checks of the affine tile background
// Busy behaviour, result timing and result contents.
// ----------------------------------------------------------------------------
module atbp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input atbp_pkg::in_word_t   cmd_word,
	input logic                 strobe,
	input atbp_pkg::out_word_t  pix_word
);
	import atbp_pkg::*;

	// once the clearing pass ends the block never blocks again
	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after the clearing pass");

	// a result comes from an accepted render word
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(start && !busy, 6) && $past(cmd_word.command, 6) == CMD_RENDER))
		else $error("result without a matching render word");

	// transparent pixels are never sent
	a_color_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> pix_word.color != 8'h00)
		else $error("result with colour zero");

	// nothing leaves during the clearing pass
	a_quiet_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !strobe)
		else $error("result during the clearing pass");

endmodule

bind affine_tile_background_pixel atbp_checker u_atbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.cmd_word (cmd_word),
	.strobe   (strobe),
	.pix_word (pix_word)
);
